>>> rtl/core/rsdc_pkg.sv
// shared types and constants for the channel-sounding step data converter
package rsdc_pkg;

    localparam int MAX_BUFFER_BYTES_DEF = 1024;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [7:0] MARKER_BYTE = 8'h80;
    localparam logic [7:0] MODE_MASK   = 8'h03;

    // position inside one step record
    typedef enum logic [1:0] {
        PH_MODE = 2'd0,
        PH_CHAN = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef struct packed {
        logic [10:0] byte_position;
        logic [7:0]  step_index;
        phase_t      header_phase;
        logic [1:0]  saved_mode;
        logic [7:0]  data_remaining;
        logic        copying_data;
        logic        record_done;
        logic [10:0] held_length;
        logic [7:0]  held_step_count;
        logic [7:0]  held_abort_idx;
        logic        held_aborted;
    } conv_state_t;

    // one converted word headed for the output queue
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        result_t r0;
        result_t r1;
    } result_pair_t;

endpackage

>>> rtl/core/rsdc_stage.sv
// step parser: per accepted word updates the record state and yields up to two results
module rsdc_stage #(
    parameter int MAX_BUFFER_BYTES = rsdc_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 first_byte,
    input  logic [10:0]          buffer_length,
    input  logic [7:0]           step_count,
    input  logic [7:0]           abort_index,
    input  logic                 subevent_aborted,
    output rsdc_pkg::result_pair_t results
);

    rsdc_pkg::conv_state_t st_reg;
    rsdc_pkg::conv_state_t st_next;

    localparam rsdc_pkg::result_t MARKER_RES = '{valid: 1'b1,
                                                 data: rsdc_pkg::MARKER_BYTE,
                                                 last: 1'b1};

    // idle until the first word of a subevent
    localparam rsdc_pkg::conv_state_t RESET_STATE = '{byte_position:   '0,
                                                      step_index:      '0,
                                                      header_phase:    rsdc_pkg::PH_MODE,
                                                      saved_mode:      '0,
                                                      data_remaining:  '0,
                                                      copying_data:    1'b0,
                                                      record_done:     1'b1,
                                                      held_length:     '0,
                                                      held_step_count: '0,
                                                      held_abort_idx:  '0,
                                                      held_aborted:    1'b0};

    always_comb begin
        rsdc_pkg::conv_state_t s;
        rsdc_pkg::result_t     r0;
        rsdc_pkg::result_t     r1;
        logic [10:0] p;
        logic [10:0] len;
        logic [11:0] nxt;
        logic        last_step;
        logic        abort_hit;

        s         = st_reg;
        r0        = '0;
        r1        = '0;
        p         = '0;
        len       = '0;
        nxt       = '0;
        last_step = 1'b0;
        abort_hit = 1'b0;

        if (accept) begin
            if (first_byte) begin
                // capture the subevent settings, clamp the buffer size
                if (32'(buffer_length) > MAX_BUFFER_BYTES) begin
                    len = 11'(MAX_BUFFER_BYTES);
                end else begin
                    len = buffer_length;
                end
                s.held_length     = len;
                s.held_step_count = step_count;
                s.held_abort_idx  = abort_index;
                s.held_aborted    = subevent_aborted;
                s.byte_position   = '0;
                s.step_index      = '0;
                s.header_phase    = rsdc_pkg::PH_MODE;
                s.saved_mode      = '0;
                s.data_remaining  = '0;
                s.copying_data    = 1'b0;
                s.record_done     = (len == '0) || (step_count == '0);
            end

            if (!s.record_done) begin
                p               = s.byte_position;
                s.byte_position = p + 11'd1;
                last_step = ({1'b0, s.step_index} + 9'd1) >= {1'b0, s.held_step_count};

                case (s.header_phase)
                    rsdc_pkg::PH_MODE: begin
                        if ({1'b0, p} + 12'd3 > {1'b0, s.held_length}) begin
                            // header cut short by the buffer end
                            r0            = MARKER_RES;
                            s.record_done = 1'b1;
                        end else begin
                            s.saved_mode   = 2'(in_byte & rsdc_pkg::MODE_MASK);
                            s.header_phase = rsdc_pkg::PH_CHAN;
                        end
                    end
                    rsdc_pkg::PH_CHAN: begin
                        s.header_phase = rsdc_pkg::PH_LEN;
                    end
                    rsdc_pkg::PH_LEN: begin
                        abort_hit = s.held_aborted && (s.step_index >= s.held_abort_idx);
                        r0.valid  = 1'b1;
                        r0.data   = {abort_hit, 5'd0, s.saved_mode};
                        r0.last   = 1'b0;
                        nxt = {1'b0, p} + 12'd1 + {4'd0, in_byte};
                        if (!abort_hit && in_byte != '0 && nxt <= {1'b0, s.held_length}) begin
                            s.copying_data   = 1'b1;
                            s.data_remaining = in_byte;
                            s.header_phase   = rsdc_pkg::PH_DATA;
                        end else begin
                            if (last_step) begin
                                r0.last       = 1'b1;
                                s.record_done = 1'b1;
                            end else if ({1'b0, nxt} + 13'd3 > {2'd0, s.held_length}) begin
                                r1            = MARKER_RES;
                                s.record_done = 1'b1;
                            end else begin
                                s.step_index   = s.step_index + 8'd1;
                                s.header_phase = rsdc_pkg::PH_MODE;
                            end
                            // skip the data of an aborted or oversized step
                            if (!s.record_done && in_byte != '0) begin
                                s.copying_data   = 1'b0;
                                s.data_remaining = in_byte;
                                s.header_phase   = rsdc_pkg::PH_DATA;
                            end
                        end
                    end
                    default: begin
                        if (s.copying_data) begin
                            r0.valid = 1'b1;
                            r0.data  = in_byte;
                            r0.last  = 1'b0;
                        end
                        if (s.data_remaining != '0) begin
                            s.data_remaining = s.data_remaining - 8'd1;
                        end
                        if (s.data_remaining == '0) begin
                            if (s.copying_data) begin
                                s.copying_data = 1'b0;
                                nxt = {1'b0, p} + 12'd1;
                                if (last_step) begin
                                    r0.last       = 1'b1;
                                    s.record_done = 1'b1;
                                end else if ({1'b0, nxt} + 13'd3 > {2'd0, s.held_length}) begin
                                    r1            = MARKER_RES;
                                    s.record_done = 1'b1;
                                end else begin
                                    s.step_index   = s.step_index + 8'd1;
                                    s.header_phase = rsdc_pkg::PH_MODE;
                                end
                            end else begin
                                s.header_phase = rsdc_pkg::PH_MODE;
                            end
                        end
                    end
                endcase
            end
        end

        st_next    = s;
        results.r0 = r0;
        results.r1 = r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= RESET_STATE;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

>>> rtl/core/rsdc_out_queue.sv
// small output queue taking up to two results per cycle and giving one per handshake
module rsdc_out_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rsdc_pkg::result_pair_t push,
    output logic                   room_for_two,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    localparam int DEPTH = rsdc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [8:0]       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;
    logic [1:0]       n_push;

    assign pop          = m_tvalid && m_tready;
    assign n_push       = {1'b0, push.r0.valid} + {1'b0, push.r1.valid};
    assign room_for_two = count_reg <= CNT_W'(DEPTH - 2);
    assign m_tvalid     = count_reg != '0;
    assign m_tdata      = mem_reg[rd_ptr_reg][8:1];
    assign m_tlast      = mem_reg[rd_ptr_reg][0];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.r0.valid) begin
            mem_reg[wr_ptr_reg] <= {push.r0.data, push.r0.last};
        end
        if (push.r1.valid) begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= {push.r1.data, push.r1.last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/ras_step_data_converter.sv
// top level of the channel-sounding step data converter
//
// usage
//   - slave channel carries the subevent step buffer one word per byte; s_tuser
//     marks the first word of a subevent, whose tdata also carries the buffer
//     length, step count, first aborted step index and aborted flag held for the record
//   - master channel gives the converted words: one mode word per step (bit 7 set
//     for aborted steps), the copied step data, and a 0x80 marker when the record
//     is cut short; m_tlast flags the last word of the record
//   - results are registered; an empty queue offers one in the cycle after its word
//   - throughput: one input word per cycle while s_tready is high; a word can cause
//     two results (a mode or last data word plus end marker), which is the one case
//     that drains slower than the input, set by the single-word output handshake
//   - a four-word output queue parts the two sides; s_tready stays high while two
//     slots are free, so a stalled receiver holds input back once three results wait
//   - reset (aresetn low, synchronous) empties the queue and leaves the block idle;
//     words without s_tuser are dropped until a new subevent starts
//   - s_tuser in mid-record abandons the current record and starts over
module ras_step_data_converter #(
    parameter int MAX_BUFFER_BYTES = rsdc_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] in_byte, [18:8] buffer_length, [26:19] step_count,
    // [34:27] abort_index, [35] subevent_aborted, [39:36] zero
    input  logic [39:0] s_tdata,
    // [0] first_byte
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_byte
    output logic [7:0]  m_tdata,
    // end_of_record
    output logic        m_tlast
);

    rsdc_pkg::result_pair_t results;
    logic                   room_for_two;
    logic                   accept;

    // take a word only when the queue can hold both possible results
    assign s_tready = room_for_two;
    assign accept   = s_tvalid && s_tready;

    rsdc_stage #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .in_byte          (s_tdata[7:0]),
        .first_byte       (s_tuser),
        .buffer_length    (s_tdata[18:8]),
        .step_count       (s_tdata[26:19]),
        .abort_index      (s_tdata[34:27]),
        .subevent_aborted (s_tdata[35]),
        .results          (results)
    );

    // result register side: converted words wait here for the receiver
    rsdc_out_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (results),
        .room_for_two (room_for_two),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

>>> rtl/core/rsdc_checker.sv
// port-level checks for the step data converter, bound to the top level
module rsdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its contents
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // results appear only after an accepted word
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result without an input word");

    // leaving reset the block is empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty after reset");

endmodule

bind ras_step_data_converter rsdc_checker u_rsdc_checker (.*);

>>> bench/testbench.sv
// self-checking testbench for the channel-sounding step data converter
`timescale 1ns / 100ps

module testbench;

    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_WORDS = 1400;

    typedef logic [7:0] byte_q_t[$];

    // one converted word as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } conv_word_t;

    // predicts the converted words of each accepted word and checks them in order
    class conversion_board;
        logic [10:0]      position;
        logic [7:0]       step_idx;
        rsdc_pkg::phase_t phase;
        logic [1:0]       mode_bits;
        logic [7:0]       data_left;
        bit               copying;
        bit               done;
        logic [10:0]      buf_len;
        logic [7:0]       step_total;
        logic [7:0]       abort_from;
        bit               aborted;
        conv_word_t       pending_words[$];
        int               produced;
        int               mismatches;

        function new();
            position = '0;
            step_idx = '0;
            phase = rsdc_pkg::PH_MODE;
            mode_bits = '0;
            data_left = '0;
            copying = 1'b0;
            done = 1'b1;
            buf_len = '0;
            step_total = '0;
            abort_from = '0;
            aborted = 1'b0;
            produced = 0;
            mismatches = 0;
        endfunction

        function void push_word(logic [7:0] data, logic last);
            conv_word_t w;
            w.data = data;
            w.last = last;
            pending_words.push_back(w);
            produced++;
        endfunction

        // end of a step; follow_pos is the buffer offset of the next step
        function void close_step(int follow_pos);
            if (int'(step_idx) + 1 >= int'(step_total)) begin
                if (produced > 0)
                    pending_words[pending_words.size() - 1].last = 1'b1;
                done = 1'b1;
                return;
            end
            if (follow_pos + 3 > int'(buf_len)) begin
                push_word(rsdc_pkg::MARKER_BYTE, 1'b1);
                done = 1'b1;
                return;
            end
            step_idx = step_idx + 8'd1;
            phase = rsdc_pkg::PH_MODE;
        endfunction

        function void accept_input(logic [39:0] word, logic first);
            logic [7:0] b;
            int p;
            int dl;
            int len;
            int follow_pos;
            bit ab;
            b = word[7:0];
            produced = 0;
            if (first) begin
                len = int'(word[18:8]);
                if (len > rsdc_pkg::MAX_BUFFER_BYTES_DEF)
                    len = rsdc_pkg::MAX_BUFFER_BYTES_DEF;
                buf_len = 11'(len);
                step_total = word[26:19];
                abort_from = word[34:27];
                aborted = word[35];
                position = '0;
                step_idx = '0;
                phase = rsdc_pkg::PH_MODE;
                mode_bits = '0;
                data_left = '0;
                copying = 1'b0;
                done = (len == 0 || step_total == 8'd0);
            end
            if (done)
                return;
            p = int'(position);
            position = position + 11'd1;
            case (phase)
                rsdc_pkg::PH_MODE: begin
                    // no room left for a whole header
                    if (p + 3 > int'(buf_len)) begin
                        push_word(rsdc_pkg::MARKER_BYTE, 1'b1);
                        done = 1'b1;
                    end else begin
                        mode_bits = 2'(b & rsdc_pkg::MODE_MASK);
                        phase = rsdc_pkg::PH_CHAN;
                    end
                end
                rsdc_pkg::PH_CHAN: phase = rsdc_pkg::PH_LEN;
                rsdc_pkg::PH_LEN: begin
                    dl = int'(b);
                    ab = aborted && (step_idx >= abort_from);
                    push_word((ab ? rsdc_pkg::MARKER_BYTE : 8'h00) | {6'b0, mode_bits}, 1'b0);
                    follow_pos = p + 1 + dl;
                    if (!ab && dl > 0 && follow_pos <= int'(buf_len)) begin
                        copying = 1'b1;
                        data_left = b;
                        phase = rsdc_pkg::PH_DATA;
                    end else begin
                        close_step(follow_pos);
                        // data of an aborted or overrunning step is skipped
                        if (!done && dl > 0) begin
                            copying = 1'b0;
                            data_left = b;
                            phase = rsdc_pkg::PH_DATA;
                        end
                    end
                end
                default: begin
                    if (copying)
                        push_word(b, 1'b0);
                    if (data_left != 8'd0)
                        data_left = data_left - 8'd1;
                    if (data_left == 8'd0) begin
                        if (copying) begin
                            copying = 1'b0;
                            close_step(p + 1);
                        end else begin
                            phase = rsdc_pkg::PH_MODE;
                        end
                    end
                end
            endcase
        endfunction

        function void check_output(logic [7:0] data, logic last);
            conv_word_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word %h last %b", data, last);
                return;
            end
            want = pending_words.pop_front();
            if (want.data !== data || want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected word %h last %b, got %h last %b",
                             want.data, want.last, data, last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    conversion_board board = new();
    int          cycle_count = 0;
    int          words_sent = 0;
    int          burst_left = 0;
    logic [31:0] stall_pat = '1;
    int          stall_hold = 0;

    ras_step_data_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // both handshakes are sampled at the rising edge, input side first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.accept_input(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                board.check_output(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stall pattern, rotated each cycle and redrawn now and then
    always @(negedge aclk) begin
        if (stall_hold == 0) begin
            stall_hold = $urandom_range(16, 80);
            stall_pat = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
        end else begin
            stall_hold--;
        end
        m_tready = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
    end

    // offer one word, with a random gap before each burst
    task automatic send_word(input logic [39:0] word, input logic first);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1, 2: gap = 0;
                7:       gap = $urandom_range(5, 14);
                default: gap = $urandom_range(1, 3);
            endcase
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = word;
        s_tuser = first;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        words_sent++;
    endtask

    // one subevent buffer; the header fields ride on the first word only
    task automatic send_record(input logic [10:0] len, input logic [7:0] steps,
                               input logic [7:0] abort_at, input logic ab,
                               input byte_q_t bytes);
        foreach (bytes[i]) begin
            if (i == 0)
                send_word({4'h0, ab, abort_at, steps, len, bytes[i]}, 1'b1);
            else
                send_word({4'h0, 28'($urandom), bytes[i]}, 1'b0);
        end
    endtask

    // mostly well-formed step buffers, with cut, overlong and noisy ones mixed in
    task automatic send_random_record();
        byte_q_t    bytes;
        int         steps;
        int         dl;
        int         len;
        int         pick;
        int         keep;
        logic [7:0] abort_at;
        logic       ab;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            steps = 0;
        else if (pick == 1)
            steps = $urandom_range(7, 255);
        else
            steps = $urandom_range(1, 6);
        for (int i = 0; i < steps && bytes.size() < 160; i++) begin
            pick = $urandom_range(0, 15);
            dl = (pick < 3) ? 0 : (pick < 15) ? $urandom_range(1, 8) : $urandom_range(9, 255);
            bytes.push_back(8'($urandom));
            bytes.push_back(8'($urandom));
            bytes.push_back(8'(dl));
            repeat (dl) bytes.push_back(8'($urandom));
        end
        if (bytes.size() == 0)
            repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom));
        ab = ($urandom_range(0, 2) == 0);
        abort_at = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, steps));
        case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = $urandom_range(1025, 2047);
            2, 3, 4: len = (bytes.size() > 4) ? bytes.size() - $urandom_range(1, 4) : 1;
            5:       len = bytes.size() + $urandom_range(1, 6);
            default: len = bytes.size();
        endcase
        // a cut buffer is abandoned by the next subevent; extra words trail a few
        if ($urandom_range(0, 9) == 0) begin
            keep = $urandom_range(1, bytes.size());
            while (bytes.size() > keep) void'(bytes.pop_back());
        end else if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom));
        end
        send_record(11'(len), 8'(steps), abort_at, ab, bytes);
    endtask

    initial begin
        byte_q_t bytes;
        int      target;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // idle block drops a word without a subevent start
        send_word({4'h0, 28'($urandom), 8'hFF}, 1'b0);
        // record abandoned mid-header by the next start
        bytes = '{8'h01, 8'h02};
        send_record(11'd10, 8'd3, 8'd0, 1'b0, bytes);
        // zero step count
        bytes = '{8'h00};
        send_record(11'd5, 8'd0, 8'd0, 1'b0, bytes);
        // zero buffer length
        bytes = '{8'hFF};
        send_record(11'd0, 8'd3, 8'd0, 1'b0, bytes);
        // oversized length, aborted from the first step
        bytes = '{8'hFF, 8'h00, 8'h02, 8'hAA};
        send_record(11'd2047, 8'd1, 8'd0, 1'b1, bytes);
        // header cut short by the buffer end
        bytes = '{8'h01, 8'h02};
        send_record(11'd2, 8'd255, 8'd255, 1'b0, bytes);
        // buffer ends before the step count is reached
        bytes = '{8'h01, 8'h22, 8'h00, 8'h33};
        send_record(11'd4, 8'd2, 8'd0, 1'b0, bytes);
        // step data runs past the buffer end
        bytes = '{8'h02, 8'h00, 8'h05, 8'h44, 8'h55};
        send_record(11'd5, 8'd1, 8'd255, 1'b1, bytes);
        // copied step followed by an aborted one
        bytes = '{8'h03, 8'h10, 8'h01, 8'hFF, 8'h00, 8'h20, 8'h00};
        send_record(11'd8, 8'd2, 8'd1, 1'b1, bytes);

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
            send_random_record();

        @(negedge aclk);
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        while (board.pending_words.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (board.pending_words.size() != 0)
            $display("ERROR: %0d converted words never arrived", board.pending_words.size());
        if (board.mismatches == 0 && board.pending_words.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
